FILE: rtl/pnis_pkg.sv
package pnis_pkg;

  localparam logic [1:0] CMD_LATTICE = 2'd0;
  localparam logic [1:0] CMD_ATOM    = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic CFG_CUTOFF = 1'b0;
  localparam logic CFG_SELF   = 1'b1;

  // squarer operand: magnitude of a cutoff, column or displacement component
  localparam int SQ_W = 34;
  localparam int DW   = 35;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } pos_t;

  // one lattice column scaled by an image shift of -1, 0 or +1
  function automatic logic signed [DW-1:0] img_term(logic signed [1:0] s,
                                                    logic [31:0] v);
    logic signed [DW-1:0] ext;
    ext = DW'($signed(v));
    if (s == 2'sb01) begin
      return ext;
    end else if (s == 2'sb11) begin
      return -ext;
    end
    return '0;
  endfunction

  function automatic logic [SQ_W-1:0] mag(logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = v[DW-1] ? -v : v;
    return a[SQ_W-1:0];
  endfunction

endpackage

FILE: rtl/pnis_atom_mem.sv
module pnis_atom_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  pnis_pkg::pos_t      wdata,
  input  logic [AW-1:0]       raddr,
  output pnis_pkg::pos_t      rdata_r
);

  pnis_pkg::pos_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/pnis_sq3.sv
module pnis_sq3 (
  input  logic                                  clk,
  input  logic [2:0][pnis_pkg::SQ_W-1:0]        op,
  output logic [2:0][2*pnis_pkg::SQ_W-1:0]      sq_r
);

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sq_r[a] <= op[a] * op[a];
    end
  end

endmodule

FILE: rtl/periodic_neighbor_image_search.sv
// Periodic neighbor image search.
// Input channel: an item is taken when start is high and busy is low. Command 0
// loads lattice column slot, command 1 loads atom position slot, command 2 asks
// which periodic images of atom partner_slot lie within the cutoff of atom slot.
// Results: out_valid marks each result for one cycle; the receiver cannot stall,
// so every result is taken when shown. out_last marks the final one of an item.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 cutoff
// radius, 1 self images) at the clock edge; write only while busy is low.
// Sequencing: a load gives its single reply in the cycle after it is taken and
// busy stays low, so loads may follow every cycle. A query runs a setup (two
// reads through the atom memory read port, cutoff square, three column squares
// and extent compares), then displacement, squarer bank, sum and compare for
// each image walked, then a closing state; a query with a slot out of range
// stops after setup. Results of a query trail its image walk by one hit.
// Reset (rst_n low, synchronous) clears the lattice, sets cutoff 0 and self
// images on; atom positions are undefined until loaded.
module periodic_neighbor_image_search #(
  parameter int MAX_ATOMS  = 64,
  parameter int MAX_EXTENT = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_slot,
  input  logic [5:0]  in_partner_slot,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [5:0]  out_center_index,
  output logic [5:0]  out_neighbor_index,
  output logic signed [1:0] out_image_a,
  output logic signed [1:0] out_image_b,
  output logic signed [1:0] out_image_c,
  output logic        out_found,
  output logic        out_last,
  output logic        out_extent_overflow
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int SW = pnis_pkg::SQ_W;
  localparam int DW = pnis_pkg::DW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDM    = 4'd1;
  localparam logic [3:0] S_DR     = 4'd2;
  localparam logic [3:0] S_RC     = 4'd3;
  localparam logic [3:0] S_COLSQ  = 4'd4;
  localparam logic [3:0] S_COLCMP = 4'd5;
  localparam logic [3:0] S_IMINIT = 4'd6;
  localparam logic [3:0] S_IMD    = 4'd7;
  localparam logic [3:0] S_IMS    = 4'd8;
  localparam logic [3:0] S_IMC    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic        accept;
  logic [31:0] cutoff_r;
  logic        self_r;
  pnis_pkg::pos_t col_r [3];
  logic [5:0]  n_r, m_r;
  logic [1:0]  c_r;
  logic [2:0]  ext_r;
  logic        ovf_r;
  logic [63:0] rc2_r;
  pnis_pkg::pos_t pn_r;
  logic signed [32:0] dr_r [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [1:0] i_r, j_r, k_r;
  logic        pend_r;
  logic signed [1:0] pi_r, pj_r, pk_r;

  logic [AW+5:0] slot_wide, m_wide;
  logic [AW-1:0] raddr;
  logic          mem_we;
  pnis_pkg::pos_t wpos, rpos;
  logic [2:0][SW-1:0]   sq_op;
  logic [2:0][2*SW-1:0] sq_r;

  logic        zero_lat;
  logic [69:0] sq_sum;
  logic [69:0] nine_rc2;
  logic        ext_c, ovf_c;
  logic        range_bad;
  logic        hit;
  logic        walk_done;
  logic signed [1:0] ext_lo [3];
  logic signed [1:0] ext_sat [3];

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign slot_wide = {{AW{1'b0}}, in_slot};
  assign m_wide    = {{AW{1'b0}}, m_r};
  assign raddr     = (state_r == S_IDLE) ? slot_wide[AW-1:0] : m_wide[AW-1:0];
  assign mem_we    = accept && (in_command == pnis_pkg::CMD_ATOM) &&
                     (32'(in_slot) < 32'(MAX_ATOMS));
  assign wpos      = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};

  pnis_atom_mem #(.DEPTH(MAX_ATOMS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(slot_wide[AW-1:0]), .wdata(wpos),
    .raddr(raddr), .rdata_r(rpos)
  );

  pnis_sq3 u_sq (.clk(clk), .op(sq_op), .sq_r(sq_r));

  always_comb begin
    sq_op = '0;
    if (state_r == S_RC) begin
      sq_op[0] = SW'(cutoff_r);
    end else if (state_r == S_COLSQ) begin
      sq_op[0] = pnis_pkg::mag(DW'($signed(col_r[c_r].x)));
      sq_op[1] = pnis_pkg::mag(DW'($signed(col_r[c_r].y)));
      sq_op[2] = pnis_pkg::mag(DW'($signed(col_r[c_r].z)));
    end else if (state_r == S_IMS) begin
      sq_op[0] = pnis_pkg::mag(d_r[0]);
      sq_op[1] = pnis_pkg::mag(d_r[1]);
      sq_op[2] = pnis_pkg::mag(d_r[2]);
    end
  end

  assign zero_lat = (col_r[0] == '0) && (col_r[1] == '0) && (col_r[2] == '0);
  assign sq_sum   = 70'(sq_r[0]) + 70'(sq_r[1]) + 70'(sq_r[2]);
  assign nine_rc2 = (70'(rc2_r) << 3) + 70'(rc2_r);

  // smallest e in 0..1 with e^2*|col|^2 >= 9*rc^2, else saturate; a zero lattice gives 0
  always_comb begin
    ext_c = 1'b0;
    ovf_c = 1'b0;
    if (!zero_lat && rc2_r != '0) begin
      if (MAX_EXTENT >= 1 && sq_sum >= nine_rc2) begin
        ext_c = 1'b1;
      end else begin
        ext_c = (MAX_EXTENT >= 1);
        ovf_c = 1'b1;
      end
    end
  end

  assign range_bad = (32'(n_r) >= 32'(MAX_ATOMS)) || (32'(m_r) >= 32'(MAX_ATOMS));
  assign hit = (sq_sum < 70'(rc2_r)) &&
               ((m_r != n_r) || (self_r && sq_sum != '0));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext_lo[a]  = ext_r[a] ? 2'sb11 : 2'sb00;
      ext_sat[a] = ext_r[a] ? 2'sb01 : 2'sb00;
    end
  end
  assign walk_done = (i_r == ext_sat[0]) && (j_r == ext_sat[1]) && (k_r == ext_sat[2]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && in_command == pnis_pkg::CMD_QUERY) state_nxt = S_RDM;
      S_RDM:    state_nxt = S_DR;
      S_DR:     state_nxt = S_RC;
      S_RC:     state_nxt = S_COLSQ;
      S_COLSQ:  state_nxt = S_COLCMP;
      S_COLCMP: state_nxt = (c_r == 2'd2) ? S_IMINIT : S_COLSQ;
      S_IMINIT: state_nxt = range_bad ? S_IDLE : S_IMD;
      S_IMD:    state_nxt = S_IMS;
      S_IMS:    state_nxt = S_IMC;
      S_IMC:    state_nxt = walk_done ? S_FIN : S_IMD;
      S_FIN:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cutoff_r  <= '0;
      self_r    <= 1'b1;
      col_r     <= '{default: '0};
      out_valid <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          pnis_pkg::CFG_CUTOFF: cutoff_r <= cfg_data;
          pnis_pkg::CFG_SELF:   self_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && in_command != pnis_pkg::CMD_QUERY) begin
        if (in_command == pnis_pkg::CMD_LATTICE && in_slot < 6'd3) begin
          col_r[in_slot[1:0]] <= wpos;
        end
        out_valid <= 1'b1;
      end
      if (state_r == S_IMINIT) begin
        pend_r <= 1'b0;
        if (range_bad) out_valid <= 1'b1;
      end
      if (state_r == S_IMC && hit) begin
        pend_r <= 1'b1;
        if (pend_r) out_valid <= 1'b1;
      end
      if (state_r == S_FIN) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      n_r <= in_slot;
      m_r <= in_partner_slot;
      out_center_index    <= '0;
      out_neighbor_index  <= '0;
      out_image_a         <= '0;
      out_image_b         <= '0;
      out_image_c         <= '0;
      out_found           <= 1'b0;
      out_last            <= 1'b1;
      out_extent_overflow <= 1'b0;
    end
    if (state_r == S_RDM) pn_r <= rpos;
    if (state_r == S_DR) begin
      dr_r[0] <= 33'($signed(pn_r.x)) - 33'($signed(rpos.x));
      dr_r[1] <= 33'($signed(pn_r.y)) - 33'($signed(rpos.y));
      dr_r[2] <= 33'($signed(pn_r.z)) - 33'($signed(rpos.z));
    end
    if (state_r == S_RC) begin
      c_r   <= 2'd0;
      ovf_r <= 1'b0;
    end
    if (state_r == S_COLSQ && c_r == 2'd0) rc2_r <= sq_r[0][63:0];
    if (state_r == S_COLCMP) begin
      ext_r[c_r] <= ext_c;
      ovf_r      <= ovf_r | ovf_c;
      c_r        <= c_r + 2'd1;
    end
    if (state_r == S_IMINIT) begin
      i_r <= ext_lo[0];
      j_r <= ext_lo[1];
      k_r <= ext_lo[2];
      if (range_bad) begin
        out_center_index    <= n_r;
        out_neighbor_index  <= m_r;
        out_image_a         <= '0;
        out_image_b         <= '0;
        out_image_c         <= '0;
        out_found           <= 1'b0;
        out_last            <= 1'b1;
        out_extent_overflow <= ovf_r;
      end
    end
    if (state_r == S_IMD) begin
      d_r[0] <= DW'(dr_r[0]) - pnis_pkg::img_term(i_r, col_r[0].x)
              - pnis_pkg::img_term(j_r, col_r[1].x) - pnis_pkg::img_term(k_r, col_r[2].x);
      d_r[1] <= DW'(dr_r[1]) - pnis_pkg::img_term(i_r, col_r[0].y)
              - pnis_pkg::img_term(j_r, col_r[1].y) - pnis_pkg::img_term(k_r, col_r[2].y);
      d_r[2] <= DW'(dr_r[2]) - pnis_pkg::img_term(i_r, col_r[0].z)
              - pnis_pkg::img_term(j_r, col_r[1].z) - pnis_pkg::img_term(k_r, col_r[2].z);
    end
    if (state_r == S_IMC) begin
      // hold the newest hit back until the next one shows whether it is last
      if (hit) begin
        pi_r <= i_r;
        pj_r <= j_r;
        pk_r <= k_r;
        if (pend_r) begin
          out_center_index    <= n_r;
          out_neighbor_index  <= m_r;
          out_image_a         <= pi_r;
          out_image_b         <= pj_r;
          out_image_c         <= pk_r;
          out_found           <= 1'b1;
          out_last            <= 1'b0;
          out_extent_overflow <= ovf_r;
        end
      end
      // advance k fastest, then j, then i
      if (k_r != ext_sat[2]) begin
        k_r <= k_r + 2'sb01;
      end else begin
        k_r <= ext_lo[2];
        if (j_r != ext_sat[1]) begin
          j_r <= j_r + 2'sb01;
        end else begin
          j_r <= ext_lo[1];
          i_r <= i_r + 2'sb01;
        end
      end
    end
    if (state_r == S_FIN) begin
      out_center_index    <= n_r;
      out_neighbor_index  <= m_r;
      out_image_a         <= pend_r ? pi_r : 2'sb00;
      out_image_b         <= pend_r ? pj_r : 2'sb00;
      out_image_c         <= pend_r ? pk_r : 2'sb00;
      out_found           <= pend_r;
      out_last            <= 1'b1;
      out_extent_overflow <= ovf_r;
    end
  end

  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_valid && out_last)
    else $error("closing cycle gave no final result");

  a_load_reply: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command != pnis_pkg::CMD_QUERY |=> out_valid && out_last && !out_found)
    else $error("load item gave no empty reply");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("empty reply not marked last");

  a_walk_emits_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IMC && hit && pend_r |=> out_valid && out_found && !out_last)
    else $error("held image not released");

endmodule

FILE: dv/periodic_neighbor_image_search_tb.sv
`timescale 1ns / 100ps

module periodic_neighbor_image_search_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [5:0]        center;
    logic [5:0]        neighbor;
    logic signed [1:0] img_a;
    logic signed [1:0] img_b;
    logic signed [1:0] img_c;
    logic              found;
    logic              last;
    logic              ovf;
  } hit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [5:0]  in_slot = '0;
  logic [5:0]  in_partner_slot = '0;
  logic [31:0] in_coord_x = '0;
  logic [31:0] in_coord_y = '0;
  logic [31:0] in_coord_z = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic [5:0]  out_center_index;
  logic [5:0]  out_neighbor_index;
  logic signed [1:0] out_image_a;
  logic signed [1:0] out_image_b;
  logic signed [1:0] out_image_c;
  logic        out_found;
  logic        out_last;
  logic        out_extent_overflow;

  // predictor state
  logic [31:0] atom_x [64];
  logic [31:0] atom_y [64];
  logic [31:0] atom_z [64];
  bit          atom_loaded [64];
  logic [31:0] lat [9];
  logic [31:0] cutoff;
  logic        self_on;

  hit_t hit_q[$];
  int   n_errors = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   n_found = 0;
  int   n_ovf = 0;
  int   quiet = 0;
  bit   no_idle = 1'b0;

  periodic_neighbor_image_search u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [127:0] square(longint v);
    logic [63:0] u;
    u = (v < 0) ? 64'(-v) : 64'(v);
    return 128'(u) * 128'(u);
  endfunction

  function automatic hit_t empty_reply(logic [5:0] c, logic [5:0] nb, logic o);
    hit_t h;
    h = '{c, nb, 2'sd0, 2'sd0, 2'sd0, 1'b0, 1'b1, o};
    return h;
  endfunction

  // list the images of atom m near atom n, as the block should
  task automatic predict_search(logic [5:0] n, logic [5:0] m);
    logic [127:0] rc2, nine, cs, lhs, d2;
    longint col [3][3];
    longint dr [3];
    longint d;
    int ext [3];
    bit ovf, zero_lat, done;
    hit_t found_q[$];
    hit_t h;
    rc2 = 128'(cutoff) * 128'(cutoff);
    nine = rc2 * 9;
    zero_lat = 1'b1;
    ovf = 1'b0;
    found_q = {};
    for (int c = 0; c < 9; c++) if (lat[c] != 0) zero_lat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      cs = '0;
      for (int a = 0; a < 3; a++) begin
        col[c][a] = $signed(lat[3*c+a]);
        cs = cs + square(col[c][a]);
      end
      ext[c] = 0;
      if (!zero_lat) begin
        done = 1'b0;
        for (int e = 0; e <= 1 && !done; e++) begin
          lhs = cs * (e * e);
          if (!(lhs < nine)) begin
            ext[c] = e;
            done = 1'b1;
          end
        end
        if (!done) begin
          ext[c] = 1;
          ovf = 1'b1;
        end
      end
    end
    dr[0] = longint'($signed(atom_x[n])) - longint'($signed(atom_x[m]));
    dr[1] = longint'($signed(atom_y[n])) - longint'($signed(atom_y[m]));
    dr[2] = longint'($signed(atom_z[n])) - longint'($signed(atom_z[m]));
    for (int i = -ext[0]; i <= ext[0]; i++)
      for (int j = -ext[1]; j <= ext[1]; j++)
        for (int k = -ext[2]; k <= ext[2]; k++) begin
          d2 = '0;
          for (int a = 0; a < 3; a++) begin
            d = dr[a] - i * col[0][a] - j * col[1][a] - k * col[2][a];
            d2 = d2 + square(d);
          end
          if ((m != n || (self_on && d2 != 0)) && d2 < rc2) begin
            h = '{n, m, 2'(i), 2'(j), 2'(k), 1'b1, 1'b0, ovf};
            found_q = {found_q, h};
          end
        end
    if (ovf) n_ovf++;
    if (found_q.size() == 0) begin
      hit_q = {hit_q, empty_reply(n, m, ovf)};
    end else begin
      found_q[found_q.size()-1].last = 1'b1;
      n_found += found_q.size();
      hit_q = {hit_q, found_q};
    end
  endtask

  task automatic predict_item(logic [1:0] cmd, logic [5:0] slot, logic [5:0] partner,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z);
    case (cmd)
      pnis_pkg::CMD_LATTICE: begin
        if (slot < 3) begin
          lat[3*slot] = x;
          lat[3*slot+1] = y;
          lat[3*slot+2] = z;
        end
        hit_q = {hit_q, empty_reply(6'd0, 6'd0, 1'b0)};
      end
      pnis_pkg::CMD_ATOM: begin
        atom_x[slot] = x;
        atom_y[slot] = y;
        atom_z[slot] = z;
        atom_loaded[slot] = 1'b1;
        hit_q = {hit_q, empty_reply(6'd0, 6'd0, 1'b0)};
      end
      pnis_pkg::CMD_QUERY: predict_search(slot, partner);
      default: hit_q = {hit_q, empty_reply(6'd0, 6'd0, 1'b0)};
    endcase
  endtask

  task automatic send_item(logic [1:0] cmd, logic [5:0] slot, logic [5:0] partner,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!no_idle && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_slot <= slot;
    in_partner_slot <= partner;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (busy);
    predict_item(cmd, slot, partner, x, y, z);
    n_items++;
  endtask

  // hold off until every expected result has come and the block has settled
  task automatic drain;
    start <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pnis_pkg::CFG_CUTOFF) cutoff = data;
    else self_on = data[0];
  endtask

  function automatic logic [31:0] near_value(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [5:0] loaded_atom();
    logic [5:0] s;
    do s = 6'($urandom_range(0, 63)); while (!atom_loaded[s]);
    return s;
  endfunction

  task automatic test_loads_and_unknown;
    send_item(pnis_pkg::CMD_ATOM, 6'd0, 6'd63, 32'h0000_0000, 32'h0000_0000,
              32'h0000_0000);
    send_item(pnis_pkg::CMD_ATOM, 6'd63, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF);
    send_item(pnis_pkg::CMD_ATOM, 6'd1, 6'd42, 32'h0001_8000, 32'h0000_4000,
              32'hFFFF_0000);
    send_item(pnis_pkg::CMD_LATTICE, 6'd3, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(pnis_pkg::CMD_LATTICE, 6'd63, 6'd63, 32'h1234_5678, 32'h0, 32'h0);
    send_item(CMD_UNUSED, 6'd21, 6'd42, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_lattice;
    // cutoff 0 lists nothing; then extent stays 0 with a real cutoff
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd1, '0, '0, '0);
    write_reg(pnis_pkg::CFG_CUTOFF, 32'h0002_0000);
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd1, '0, '0, '0);
    send_item(pnis_pkg::CMD_QUERY, 6'd1, 6'd1, '0, '0, '0);
  endtask

  task automatic test_overflow_and_self;
    send_item(pnis_pkg::CMD_LATTICE, 6'd0, 6'd0, 32'h0001_8000, 32'h0, 32'h0);
    send_item(pnis_pkg::CMD_LATTICE, 6'd1, 6'd0, 32'h0, 32'h0003_0000, 32'h0);
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd1, '0, '0, '0);
    send_item(pnis_pkg::CMD_QUERY, 6'd1, 6'd1, '0, '0, '0);
    send_item(pnis_pkg::CMD_LATTICE, 6'd2, 6'd0, 32'h0, 32'h0, 32'h0001_0000);
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd0, '0, '0, '0);
    write_reg(pnis_pkg::CFG_SELF, 32'd0);
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd0, '0, '0, '0);
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd1, '0, '0, '0);
    write_reg(pnis_pkg::CFG_SELF, 32'd1);
  endtask

  task automatic test_extremes;
    write_reg(pnis_pkg::CFG_CUTOFF, 32'hFFFF_FFFF);
    send_item(pnis_pkg::CMD_LATTICE, 6'd0, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000);
    send_item(pnis_pkg::CMD_QUERY, 6'd0, 6'd63, '0, '0, '0);
    send_item(pnis_pkg::CMD_QUERY, 6'd63, 6'd63, '0, '0, '0);
    send_item(pnis_pkg::CMD_QUERY, 6'd63, 6'd1, '0, '0, '0);
  endtask

  task automatic test_random(int count);
    logic [1:0] cmd;
    logic [5:0] slot, partner;
    logic [31:0] v [3];
    int r;
    for (int it = 0; it < count; it++) begin
      if (it % 80 == 0) begin
        write_reg(pnis_pkg::CFG_CUTOFF, (it == 160) ? 32'hFFFF_FFFF :
                  (it == 240) ? 32'h0 : 32'($urandom_range(32'h1_0000, 32'h6_0000)));
        write_reg(pnis_pkg::CFG_SELF, 32'($urandom_range(0, 1)));
      end
      no_idle = (it >= 100 && it < 180);
      r = $urandom_range(0, 99);
      cmd = (r < 20) ? pnis_pkg::CMD_LATTICE : (r < 42) ? pnis_pkg::CMD_ATOM :
            (r < 95) ? pnis_pkg::CMD_QUERY : CMD_UNUSED;
      slot = 6'($urandom_range(0, 63));
      partner = 6'($urandom_range(0, 63));
      for (int a = 0; a < 3; a++)
        v[a] = ($urandom_range(0, 99) < 88) ? near_value(32'h6_0000) : $urandom;
      if (cmd == pnis_pkg::CMD_LATTICE) begin
        if ($urandom_range(0, 9) != 0) slot = 6'($urandom_range(0, 2));
        if ($urandom_range(0, 11) == 0) v = '{32'h0, 32'h0, 32'h0};
      end else if (cmd == pnis_pkg::CMD_QUERY) begin
        slot = loaded_atom();
        partner = ($urandom_range(0, 5) == 0) ? slot : loaded_atom();
      end
      send_item(cmd, slot, partner, v[0], v[1], v[2]);
      if (it == 200) drain();
    end
  endtask

  // results cannot be held off: check every strobe against the oldest expectation
  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result center=%0d neighbor=%0d", $time,
                 out_center_index, out_neighbor_index);
        n_errors++;
      end else begin
        e = hit_q.pop_front();
        if (out_center_index !== e.center || out_neighbor_index !== e.neighbor ||
            out_image_a !== e.img_a || out_image_b !== e.img_b ||
            out_image_c !== e.img_c || out_found !== e.found ||
            out_last !== e.last || out_extent_overflow !== e.ovf) begin
          $display("%0t: mismatch exp c=%0d n=%0d img=(%0d,%0d,%0d) f=%b l=%b o=%b",
                   $time, e.center, e.neighbor, e.img_a, e.img_b, e.img_c,
                   e.found, e.last, e.ovf);
          $display("%0t:          got c=%0d n=%0d img=(%0d,%0d,%0d) f=%b l=%b o=%b",
                   $time, out_center_index, out_neighbor_index, out_image_a,
                   out_image_b, out_image_c, out_found, out_last, out_extent_overflow);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("[periodic_neighbor_image_search] ERROR");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < 64; s++) atom_loaded[s] = 1'b0;
    for (int c = 0; c < 9; c++) lat[c] = '0;
    cutoff = '0;
    self_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_loads_and_unknown();
    test_zero_lattice();
    test_overflow_and_self();
    test_extremes();
    test_random(300);
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d items, checked %0d results (%0d images found, %0d saturated queries).",
             n_items, n_results, n_found, n_ovf);
    $display("Cutoff swept from 0 to full scale, self images on and off, zero columns hit.");
    if (n_errors == 0 && hit_q.size() == 0) begin
      $display("[periodic_neighbor_image_search] OK");
    end else begin
      $display("[periodic_neighbor_image_search] ERROR");
    end
    $finish;
  end

endmodule
